// ----- hdl/bfiq_pkg.sv -----
// ----------------------------------------------------------------------------
// bfiq_pkg
// Shared types, constants and the rotate function of the Bloom filter block.
// ----------------------------------------------------------------------------
package bfiq_pkg;

	localparam int unsigned MAX_WORDS_DEF  = 1024;
	localparam int unsigned MAX_HASHES_DEF = 6;
	localparam int unsigned WORD_BITS      = 32;
	localparam int unsigned CFG_IDX_W      = 3;
	localparam int unsigned CFG_DATA_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BITMAP_WORDS = 3'd1;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_TEST   = 1'b1;

	localparam logic [31:0] C1 = 32'hcc9e2d51;
	localparam logic [31:0] C2 = 32'h1b873593;
	localparam logic [31:0] C3 = 32'he6546b64;
	localparam logic [31:0] F1 = 32'h85ebca6b;
	localparam logic [31:0] F2 = 32'hc2b2ae35;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_K1,
		ST_K2,
		ST_MIX,
		ST_F1,
		ST_F2,
		ST_MOD,
		ST_RD,
		ST_WAIT,
		ST_UPD,
		ST_DONE
	} state_t;

	// Operand select for the shared multiplier
	typedef enum logic [2:0] {
		MS_K1,
		MS_K2,
		MS_H5,
		MS_F1,
		MS_F2
	} mul_sel_t;

	typedef struct packed {
		logic        mem_rd;
		logic        mem_wr;
	} mem_ctl_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
		return (x << r) | (x >> (32 - r));
	endfunction

endpackage

// ----- hdl/bfiq_mem.sv -----
// ----------------------------------------------------------------------------
// bfiq_mem
// Bit array memory: one read or write port, registered read data.
// ----------------------------------------------------------------------------
module bfiq_mem import bfiq_pkg::*; #(
	parameter int unsigned MAX_WORDS = MAX_WORDS_DEF,
	localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
	input  logic          clk,
	input  mem_ctl_t      ctl,
	input  logic [AW-1:0] addr,
	input  logic [31:0]   wdata,
	output logic [31:0]   rdata
);

	logic [31:0] mem [MAX_WORDS];

	always_ff @(posedge clk) begin
		if (ctl.mem_wr) begin
			mem[addr] <= wdata;
		end
		if (ctl.mem_rd) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ----- hdl/bloom_filter_insert_query_top.sv -----
// ----------------------------------------------------------------------------
// bloom_filter_insert_query_top
// Bloom filter, MurmurHash3 of 32-bit keys, insert and membership test.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken when start is high and busy low.
//   func selects insert (0) or test (1); key is the 32-bit key.
//   Result: done strobes for one cycle with was_insert and member.
//   Configuration: cfg_we/cfg_idx/cfg_data write registers while idle.
// Sequence: after reset a clearing pass zeroes every memory word (busy high).
//   Each hash runs the K1, K2, MIX, F1 and F2 steps on one shared 32x32
//   multiplier, the 32-step restoring divider of the modulo and the read,
//   wait and update steps of the memory (written back on insert only).
//   done strobes once the last of the configured hashes is through.
// Throughput: one item at a time, busy high for the whole computation; the
//   next transaction can be taken at the edge that ends the done cycle.
// The receiver cannot stall; the result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query_top import bfiq_pkg::*; #(
	parameter int unsigned MAX_WORDS  = MAX_WORDS_DEF,
	parameter int unsigned MAX_HASHES = MAX_HASHES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  func,
	input  logic [31:0]           key,
	output logic                  done,
	output logic                  was_insert,
	output logic                  member,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int unsigned CW = $clog2(MAX_WORDS + 1);

	logic [2:0]  hash_count_q;
	logic [10:0] bitmap_words_q;
	logic [31:0] seed_q [6];

	state_t      state_q, state_d;
	logic [31:0] k_q, h_q;
	logic [31:0] key_hold_q;
	logic        func_q, all_set_q;
	logic [2:0]  hidx_q;
	logic [5:0]  step_q;
	logic [31:0] rem_q, quo_q;
	logic        clr_q;
	logic [CW-1:0] clr_cnt_q;
	logic [31:0] prod;
	mul_sel_t    ms;
	logic [31:0] ma, mb;
	mem_ctl_t    mctl;
	logic [AW-1:0] maddr;
	logic [31:0] mwdata, mrdata;
	logic [2:0]  n_used;
	logic [10:0] w_used;
	logic [15:0] nbits;
	logic [32:0] rem_sh;
	logic [4:0]  bpos;
	logic [AW-1:0] widx;

	// Clamped configuration
	always_comb begin
		n_used = hash_count_q;
		if (n_used == 3'd0) n_used = 3'd1;
		if (32'(n_used) > MAX_HASHES) n_used = 3'(MAX_HASHES);
		w_used = bitmap_words_q;
		if (w_used == 11'd0) w_used = 11'd1;
		if (32'(w_used) > MAX_WORDS) w_used = 11'(MAX_WORDS);
		nbits = {w_used, 5'd0};
	end

	// Shared multiplier
	always_comb begin
		ma = k_q;
		mb = C1;
		unique case (ms)
			MS_K1: begin ma = k_q; mb = C1; end
			MS_K2: begin ma = k_q; mb = C2; end
			MS_H5: begin ma = h_q; mb = 32'd5; end
			MS_F1: begin ma = h_q; mb = F1; end
			MS_F2: begin ma = h_q; mb = F2; end
			default: begin ma = k_q; mb = C1; end
		endcase
		prod = 32'(ma * mb);
	end

	assign rem_sh = {rem_q, quo_q[31]};
	assign bpos   = rem_q[4:0];
	// Remainder is below the bit count in use, so the word index stays in range
	assign widx   = AW'(rem_q[31:5]);

	always_comb begin
		state_d = state_q;
		ms      = MS_K1;
		mctl    = '0;
		maddr   = widx;
		mwdata  = mrdata | (32'd1 << bpos);
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = clr_q;
				maddr = AW'(clr_cnt_q);
				mwdata = '0;
				mctl.mem_wr = clr_q;
				if (!clr_q && start) state_d = ST_K1;
			end
			ST_K1:  begin ms = MS_K1; state_d = ST_K2; end
			ST_K2:  begin ms = MS_K2; state_d = ST_MIX; end
			ST_MIX: begin ms = MS_H5; state_d = ST_F1; end
			ST_F1:  begin ms = MS_F1; state_d = ST_F2; end
			ST_F2:  begin ms = MS_F2; state_d = ST_MOD; end
			ST_MOD: if (step_q == 6'd32) state_d = ST_RD;
			ST_RD:  begin mctl.mem_rd = 1'b1; state_d = ST_WAIT; end
			ST_WAIT: state_d = ST_UPD;
			ST_UPD: begin
				mctl.mem_wr = (func_q == FUNC_INSERT);
				state_d = (hidx_q + 3'd1 >= n_used) ? ST_DONE : ST_K1;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
			done <= 1'b0;
			hash_count_q <= 3'd1;
			bitmap_words_q <= 11'd1024;
			for (int i = 0; i < 6; i++) seed_q[i] <= 32'(i);
		end else begin
			state_q <= state_d;
			done <= (state_q == ST_DONE);
			if (clr_q) begin
				if (32'(clr_cnt_q) == MAX_WORDS - 1) clr_q <= 1'b0;
				clr_cnt_q <= clr_cnt_q + CW'(1);
			end
			if (cfg_we) begin
				if (cfg_idx == REG_HASH_COUNT) hash_count_q <= cfg_data[2:0];
				else if (cfg_idx == REG_BITMAP_WORDS) bitmap_words_q <= cfg_data[10:0];
				else seed_q[cfg_idx - 3'd2] <= cfg_data;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				func_q <= func;
				k_q <= key;
				all_set_q <= 1'b1;
				hidx_q <= 3'd0;
				h_q <= seed_q[0];
			end
			ST_K1: k_q <= rotl(prod, 15);
			ST_K2: h_q <= rotl(h_q ^ prod, 13);
			ST_MIX: begin
				h_q <= ((prod + C3) ^ 32'd4) ^ (((prod + C3) ^ 32'd4) >> 16);
			end
			ST_F1: h_q <= prod ^ (prod >> 13);
			ST_F2: begin
				quo_q <= prod ^ (prod >> 16);
				rem_q <= '0;
				step_q <= '0;
			end
			ST_MOD: if (step_q != 6'd32) begin
				if (rem_sh >= {17'd0, nbits}) rem_q <= 32'(rem_sh - {17'd0, nbits});
				else rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
				step_q <= step_q + 6'd1;
			end
			ST_UPD: begin
				if (mrdata[bpos] == 1'b0) all_set_q <= 1'b0;
				hidx_q <= hidx_q + 3'd1;
				k_q <= key_hold_q;
				h_q <= seed_q[hidx_q + 3'd1];
			end
			ST_DONE: begin
				was_insert <= (func_q == FUNC_INSERT);
				member <= (func_q == FUNC_TEST) && all_set_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) key_hold_q <= key;
	end

	bfiq_mem #(.MAX_WORDS(MAX_WORDS)) u_mem (
		.clk(clk), .ctl(mctl), .addr(maddr), .wdata(mwdata), .rdata(mrdata)
	);

	a_busy_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_DONE)) else $error("done without finish");
	a_no_wr_test: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD && func_q == FUNC_TEST) |-> !mctl.mem_wr)
		else $error("test wrote memory");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> (rem_q < {16'd0, nbits})) else $error("modulo out of range");

endmodule

// ----- dv/bloom_filter_insert_query_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_insert_query_top_tb
// Drives insert and test transactions through several register settings,
// keeps its own copy of the bit array and hash seeds, and checks each strobed
// result against a queue of predicted answers.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query_top_tb;
	import bfiq_pkg::*;

	localparam int N_WORDS    = 1024;
	localparam int LIMIT      = 2000000;
	localparam int HOLD_OFF   = 600;
	localparam int N_RANDOM   = 500;

	typedef struct packed {
		logic was_insert;
		logic member;
	} answer_t;

	typedef struct {
		logic        func;
		logic [31:0] key;
		logic        fixed;
		answer_t     want;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  func = 1'b0;
	logic [31:0]           key = '0;
	logic                  done;
	logic                  was_insert;
	logic                  member;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [31:0] filter_bits [N_WORDS];
	logic [2:0]  n_hashes_reg;
	logic [10:0] n_words_reg;
	logic [31:0] seed_reg [6];
	answer_t     pending_answers [$];
	int          errors = 0;
	int          cycles = 0;
	row_t        rows [$];

	bloom_filter_insert_query_top dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("%0t timeout", $time);
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [31:0] rot(input logic [31:0] x, input int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic logic [31:0] murmur(input logic [31:0] k_in, input logic [31:0] s);
		logic [31:0] k;
		logic [31:0] h;
		k = k_in * 32'hcc9e2d51;
		k = rot(k, 15);
		k = k * 32'h1b873593;
		h = s ^ k;
		h = rot(h, 13);
		h = h * 32'd5 + 32'he6546b64;
		h = h ^ 32'd4;
		h = h ^ (h >> 16);
		h = h * 32'h85ebca6b;
		h = h ^ (h >> 13);
		h = h * 32'hc2b2ae35;
		h = h ^ (h >> 16);
		return h;
	endfunction

	// update the filter copy on an insert and return the answer the block must give
	function automatic answer_t filter_lookup(input logic f, input logic [31:0] k);
		int unsigned n;
		int unsigned nbits;
		int unsigned pos;
		logic        all_set;
		answer_t     a;
		n = (n_hashes_reg == 0) ? 1 : (n_hashes_reg > 6) ? 6 : n_hashes_reg;
		nbits = ((n_words_reg == 0) ? 1 : (n_words_reg > N_WORDS) ? N_WORDS : n_words_reg) * 32;
		all_set = 1'b1;
		for (int i = 0; i < n; i++) begin
			pos = murmur(k, seed_reg[i]) % nbits;
			if (f == FUNC_TEST) begin
				if (!filter_bits[pos >> 5][pos & 31]) all_set = 1'b0;
			end else begin
				filter_bits[pos >> 5][pos & 31] = 1'b1;
			end
		end
		a.was_insert = (f == FUNC_INSERT);
		a.member = (f == FUNC_TEST) && all_set;
		return a;
	endfunction

	always @(posedge clk) begin
		answer_t got;
		answer_t want;
		if (done) begin
			got.was_insert = was_insert;
			got.member = member;
			if (pending_answers.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %b", $time, got);
				errors++;
			end else begin
				want = pending_answers.pop_front();
				if (got.was_insert !== want.was_insert)
					begin
					$display("%0t was_insert: expected %b actual %b", $time,
						want.was_insert, got.was_insert);
					errors++;
				end
				if (got.member !== want.member) begin
					$display("%0t member: expected %b actual %b", $time,
						want.member, got.member);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_HASH_COUNT:   n_hashes_reg = val[2:0];
			REG_BITMAP_WORDS: n_words_reg = val[10:0];
			default:          if (idx < 8) seed_reg[idx - 2] = val;
		endcase
	endtask

	// wait for all answers, then let the block settle before touching registers
	task automatic drain();
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	// issue one transaction; fixed rows carry a typed-in expectation
	task automatic issue(input logic f, input logic [31:0] k, input logic fixed,
			input answer_t want);
		answer_t p;
		@(posedge clk);
		start <= 1'b1;
		func <= f;
		key <= k;
		@(posedge clk);
		while (busy) @(posedge clk);
		p = filter_lookup(f, k);
		if (fixed && p !== want) begin
			$display("%0t table row key %h: expected %b predicted %b", $time, k, want, p);
			errors++;
		end
		pending_answers.push_back(p);
		start <= 1'b0;
	endtask

	task automatic random_phase(input int count, input int key_span);
		int burst;
		logic [31:0] k;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (burst == 0) begin
				repeat ($urandom_range(0, 40)) @(posedge clk);
				burst = $urandom_range(1, 12);
			end
			burst--;
			// narrow keys give repeated keys, so tests hit inserted entries
			k = (key_span == 0) ? $urandom() : $urandom_range(0, key_span);
			issue(1'($urandom_range(0, 1)), k, 1'b0, '0);
		end
	endtask

	function automatic row_t mk(input logic f, input logic [31:0] k, input logic fx,
			input logic wi, input logic mb);
		row_t r;
		r.func = f;
		r.key = k;
		r.fixed = fx;
		r.want.was_insert = wi;
		r.want.member = mb;
		return r;
	endfunction

	initial begin
		for (int i = 0; i < N_WORDS; i++) filter_bits[i] = '0;
		n_hashes_reg = 3'd1;
		n_words_reg = 11'd1024;
		for (int i = 0; i < 6; i++) seed_reg[i] = i;

		// empty filter: tests miss, inserts acknowledge, inserted keys hit
		rows.push_back(mk(FUNC_TEST,   32'h0000_0000, 1'b1, 1'b0, 1'b0));
		rows.push_back(mk(FUNC_TEST,   32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0));
		rows.push_back(mk(FUNC_INSERT, 32'h0000_0000, 1'b1, 1'b1, 1'b0));
		rows.push_back(mk(FUNC_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0));
		rows.push_back(mk(FUNC_TEST,   32'h0000_0000, 1'b1, 1'b0, 1'b1));
		rows.push_back(mk(FUNC_TEST,   32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1));
		rows.push_back(mk(FUNC_INSERT, 32'hA5A5_5A5A, 1'b1, 1'b1, 1'b0));
		rows.push_back(mk(FUNC_TEST,   32'hA5A5_5A5A, 1'b1, 1'b0, 1'b1));
		rows.push_back(mk(FUNC_TEST,   32'h1234_5678, 1'b0, 1'b0, 1'b0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		foreach (rows[i]) issue(rows[i].func, rows[i].key, rows[i].fixed, rows[i].want);
		drain();

		// six hashes, one word, zero seeds for the corner
		write_reg(REG_HASH_COUNT, 32'd6);
		write_reg(REG_BITMAP_WORDS, 32'd1);
		for (int i = 2; i < 8; i++) write_reg(i[2:0], 32'd0);
		issue(FUNC_INSERT, 32'h8000_0001, 1'b0, '0);
		issue(FUNC_TEST, 32'h8000_0001, 1'b0, '0);
		issue(FUNC_TEST, 32'h7FFF_FFFE, 1'b0, '0);
		drain();

		// zero and oversized values saturate; all-ones seeds
		write_reg(REG_HASH_COUNT, 32'd0);
		write_reg(REG_BITMAP_WORDS, 32'd0);
		for (int i = 2; i < 8; i++) write_reg(i[2:0], 32'hFFFF_FFFF);
		issue(FUNC_TEST, 32'h0000_00FF, 1'b0, '0);
		issue(FUNC_INSERT, 32'h0000_00FF, 1'b0, '0);
		drain();
		write_reg(REG_HASH_COUNT, 32'd7);
		write_reg(REG_BITMAP_WORDS, 32'h7FF);
		issue(FUNC_TEST, 32'hDEAD_BEEF, 1'b0, '0);
		issue(FUNC_INSERT, 32'hDEAD_BEEF, 1'b0, '0);
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_HASH_COUNT, $urandom_range(0, 7));
			write_reg(REG_BITMAP_WORDS, (ph == 0) ? 32'd1024 : $urandom_range(0, 2047));
			for (int i = 2; i < 8; i++) write_reg(i[2:0], $urandom());
			random_phase(N_RANDOM / 10, 0);
			random_phase(N_RANDOM / 10, 63);
			drain();
		end

		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ----- bloom_filter_insert_query_top.f -----
hdl/bfiq_pkg.sv
hdl/bfiq_mem.sv
hdl/bloom_filter_insert_query_top.sv
dv/bloom_filter_insert_query_top_tb.sv
